// ===== hw/rtl/ffa_pkg.sv =====
// Shared types and constants of the forest-fire automaton step block.
// No dependencies; every other file of the block imports this package.
package ffa_pkg;

    // Default largest grid side and the side length loaded at reset.
    localparam int MAX_SIDE_DEF    = 64;
    localparam int GRID_SIZE_RESET = 64;

    // Width of the grid size register.
    localparam int CFG_W = 7;

    // Cell state codes.
    typedef enum logic [1:0] {
        CELL_GROUND = 2'd0,
        CELL_TREE   = 2'd1,
        CELL_FIRE   = 2'd2,
        CELL_OTHER  = 2'd3
    } t_cell;

    // 3x3 neighborhood, [row][column], column 2 holding the newest cell.
    typedef t_cell t_win [3][3];

    // Grid edges around the cell that is being updated.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_bnd;

endpackage

// ===== hw/rtl/forest_fire_automaton_step_top.sv =====
// Top level of the forest-fire automaton step; instantiates ffa_line_store and
// ffa_rule and imports ffa_pkg.
//
// This block computes one generation of a forest-fire automaton over a square grid
// whose cells stream in raster order, one beat per cell. Fire becomes ground, a tree
// catches fire when one of its four orthogonal neighbors burns, ground grows a tree
// when more than one of its eight neighbors is a tree, and code 3 passes unchanged;
// cells beyond the grid edge count as empty. Two line stores of MAX_SIDE entries
// feed a 3x3 window register, and the rule logic sits between that window and the
// output register, so the block takes one beat per clock cycle for as long as the
// output side takes results; the result of the beat that completes its window is
// loaded into the output register once the output register is free. A result
// is due one row plus one cell after its cell, so after the frame's last cell the
// user sends grid_size + 1 flush beats (tuser high) to drain the remaining results;
// tlast marks the result for the grid's final cell, after which the next beat
// starts a new frame. Writing the grid size restarts the frame; a value of 0 acts
// as 1 and a value above MAX_SIDE acts as MAX_SIDE. After reset the block clears
// its line stores, one entry per cycle, with s_axis_tready low; configuration
// writes are taken during that pass.
module forest_fire_automaton_step_top
    import ffa_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write channel: grid size.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Input cell stream.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [1:0] cell_code, [7:2] zero
    input  logic             s_axis_tuser,   // [0] mode (flush beat when high)
    // Result stream.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] next_cell, [7:2] zero
    output logic             m_axis_tlast    // last_of_frame
);

    // Column index width, side length width and input row width (the row can
    // run up to side + 1 before the frame wraps).
    localparam int AW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int RW = $clog2(MAX_SIDE + 2);
    localparam int CW = (SW > CFG_W) ? SW : CFG_W;
    localparam int RESET_SIDE = (GRID_SIZE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIZE_RESET;

    // Configuration: the clamped side length is kept rather than the raw value.
    logic [SW-1:0] r_side;
    logic [SW-1:0] side_m1;
    logic [CW-1:0] cfg_ext;
    logic [SW-1:0] cfg_side;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_ext     = CW'(i_cfg_data);
    assign side_m1     = r_side - SW'(1);

    always_comb begin
        priority if (cfg_ext == '0) begin
            cfg_side = SW'(1);
        end else if (cfg_ext > CW'(MAX_SIDE)) begin
            cfg_side = SW'(MAX_SIDE);
        end else begin
            cfg_side = SW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SW'(RESET_SIDE);
        end else if (cfg_wr) begin
            r_side <= cfg_side;
        end
    end

    // Clearing pass over the line stores after reset.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_SIDE - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Pipeline handshake: the window register feeds stage one, whose result
    // goes to the output register.
    logic  r_s1_vld;
    t_bnd  r_s1_bnd;
    logic  r_out_vld;
    t_cell r_out_cell;
    logic  r_out_last;
    logic  s1_move;
    logic  in_acc;

    assign s1_move       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_vld || s1_move);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Stream position of the next input beat and of the next result.
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_ocol;
    logic [AW-1:0] r_orow;
    logic [AW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [AW-1:0] n_ocol;
    logic [AW-1:0] n_orow;

    logic  row_in_grid;
    logic  col_end;
    logic  do_emit;
    t_bnd  cur_bnd;
    t_cell cur_cell;

    assign row_in_grid = r_row < RW'(r_side);
    assign col_end     = SW'(r_col) == side_m1;
    // No result until one row plus one cell has gone in.
    assign do_emit     = !((r_row == '0) || ((r_row == RW'(1)) && (r_col == '0)));

    assign cur_bnd.top    = (r_orow == '0);
    assign cur_bnd.bottom = (SW'(r_orow) == side_m1);
    assign cur_bnd.left   = (r_ocol == '0);
    assign cur_bnd.right  = (SW'(r_ocol) == side_m1);
    assign cur_bnd.last   = cur_bnd.bottom && cur_bnd.right;

    // Flush beats and beats past the grid's last row enter as ground.
    assign cur_cell = (!s_axis_tuser && row_in_grid) ? t_cell'(s_axis_tdata[1:0])
                                                     : CELL_GROUND;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        priority if (cfg_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_ocol = '0;
            n_orow = '0;
        end else if (in_acc) begin
            if (do_emit && cur_bnd.last) begin
                // The final result of the frame: the next beat starts a new frame.
                n_col  = '0;
                n_row  = '0;
                n_ocol = '0;
                n_orow = '0;
            end else begin
                if (col_end) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = r_col + AW'(1);
                end
                if (do_emit) begin
                    if (cur_bnd.right) begin
                        n_ocol = '0;
                        n_orow = r_orow + AW'(1);
                    end else begin
                        n_ocol = r_ocol + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // Line stores. The read address always follows the next beat's column, so the
    // registered read data is ready when that beat arrives. The upper store takes
    // what the middle store held, the middle store takes the incoming cell.
    t_cell         up_rd;
    t_cell         mid_rd;
    logic          ls_we;
    logic [AW-1:0] ls_waddr;
    t_cell         up_wdata;
    t_cell         mid_wdata;

    assign ls_we     = r_clr_busy || in_acc;
    assign ls_waddr  = r_clr_busy ? r_clr_addr : r_col;
    assign up_wdata  = r_clr_busy ? CELL_GROUND : mid_rd;
    assign mid_wdata = r_clr_busy ? CELL_GROUND : cur_cell;

    ffa_line_store #(
        .DEPTH (MAX_SIDE)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (up_wdata),
        .i_raddr (n_col),
        .o_rdata (up_rd)
    );

    ffa_line_store #(
        .DEPTH (MAX_SIDE)
    ) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (mid_wdata),
        .i_raddr (n_col),
        .o_rdata (mid_rd)
    );

    // 3x3 window register, shifted left by one column on every accepted beat.
    t_win r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= CELL_GROUND;
                end
            end
        end else if (in_acc) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= up_rd;
            r_win[1][2] <= mid_rd;
            r_win[2][2] <= cur_cell;
        end
    end

    // Stage one: the edge flags that belong to the window just loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= do_emit;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_bnd <= cur_bnd;
        end
    end

    t_cell rule_next;

    ffa_rule u_rule (
        .i_win  (r_win),
        .i_bnd  (r_s1_bnd),
        .o_next (rule_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_cell <= rule_next;
            r_out_last <= r_s1_bnd.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out_cell};
    assign m_axis_tlast  = r_out_last;

    // The input column never reaches the side length.
    a_col_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_col) < r_side)
        else $error("input column outside the grid");

    // The input row never runs past the side length plus one.
    a_row_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(r_side) + RW'(1))
        else $error("input row beyond the flush region");

    // While a frame's final result waits and no later result is queued behind it,
    // the result position is back at the start.
    a_last_wraps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && !r_s1_vld) |-> ((r_orow == '0) && (r_ocol == '0)))
        else $error("result position not restarted after the final cell");

    // Nothing is in flight during the clearing pass.
    a_clear_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_vld && !r_out_vld))
        else $error("result pending while the line stores are cleared");

endmodule

// ===== hw/rtl/ffa_line_store.sv =====
// One row of cell states, one write and one registered read per cycle.
// Depends on ffa_pkg for the cell type.
module ffa_line_store
    import ffa_pkg::*;
#(
    parameter int DEPTH = MAX_SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_cell                    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_cell                    o_rdata
);

    t_cell mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // A write to the address being read is passed straight to the read register.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ffa_rule.sv =====
// Next-generation rule for the center of a 3x3 window, with grid edges masked.
// Depends on ffa_pkg for the cell, window and edge types.
module ffa_rule
    import ffa_pkg::*;
(
    input  t_win  i_win,
    input  t_bnd  i_bnd,
    output t_cell o_next
);

    logic [3:0] trees;
    logic       fire_orth;

    always_comb begin
        logic inside_grid;
        trees     = 4'd0;
        fire_orth = 1'b0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                inside_grid = !((dr == 0) && i_bnd.top) && !((dr == 2) && i_bnd.bottom) &&
                              !((dc == 0) && i_bnd.left) && !((dc == 2) && i_bnd.right);
                if (!((dr == 1) && (dc == 1)) && inside_grid) begin
                    if (i_win[dr][dc] == CELL_TREE) begin
                        trees = trees + 4'd1;
                    end
                    if ((i_win[dr][dc] == CELL_FIRE) && ((dr == 1) || (dc == 1))) begin
                        fire_orth = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (i_win[1][1])
            CELL_FIRE:   o_next = CELL_GROUND;
            CELL_TREE:   o_next = fire_orth ? CELL_FIRE : CELL_TREE;
            CELL_GROUND: o_next = (trees > 4'd1) ? CELL_TREE : CELL_GROUND;
            default:     o_next = CELL_OTHER;
        endcase
    end

endmodule

// ===== verif/ffa_result_checker.sv =====
`timescale 1ns / 1ps
// Passive checker for the forest-fire automaton step: watches the grid size,
// cell and result channels, predicts each next-generation cell and compares it.
// Depends on ffa_pkg for the cell codes, the window type and the register width.
module ffa_result_checker
    import ffa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_valid,
    input  logic             i_s_ready,
    input  logic [7:0]       i_s_data,    // [1:0] cell_code, [7:2] zero
    input  logic             i_s_user,    // [0] mode
    input  logic             i_m_valid,
    input  logic             i_m_ready,
    input  logic [7:0]       i_m_data,    // [1:0] next_cell, [7:2] zero
    input  logic             i_m_last,    // last_of_frame
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct {
        t_cell code;
        logic  last;
    } t_due;

    t_due             due_cells[$];
    logic [CFG_W-1:0] side_reg;
    t_cell            upper_line [MAX_SIDE_DEF];
    t_cell            middle_line [MAX_SIDE_DEF];
    t_win             win;
    int               col_pos;
    int               row_pos;
    int               emit_cnt;

    function automatic int eff_side();
        int s;
        s = int'(side_reg);
        if (s < 1) s = 1;
        if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
        return s;
    endfunction

    function automatic void restart_frame();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win[r][c] = CELL_GROUND;
        col_pos  = 0;
        row_pos  = 0;
        emit_cnt = 0;
    endfunction

    // Advances the stream by one beat; returns 1 when a result falls due.
    function automatic bit step_automaton(input logic flush, input t_cell code,
                                          output t_cell nxt, output logic last);
        int    n, total, c, k, orow, ocol, rr, cc, trees, fires;
        t_cell v, a, b, ctr, nb;
        n     = eff_side();
        total = n * n;
        c     = col_pos % n;
        k     = row_pos * n + c;
        v     = (!flush && k < total) ? code : CELL_GROUND;
        a     = upper_line[c];
        b     = middle_line[c];
        upper_line[c]  = b;
        middle_line[c] = v;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = a;
        win[1][2] = b;
        win[2][2] = v;
        c++;
        if (c >= n) begin
            c = 0;
            if (row_pos < 'hFFFF) row_pos++;
        end
        col_pos = c;
        nxt  = CELL_GROUND;
        last = 1'b0;
        if (k < n + 1 || emit_cnt >= total) return 1'b0;

        orow  = emit_cnt / n;
        ocol  = emit_cnt % n;
        trees = 0;
        fires = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = orow + dr;
                cc = ocol + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < n && cc >= 0 && cc < n) begin
                    nb = win[dr + 1][dc + 1];
                    if (nb == CELL_TREE) trees++;
                    if (nb == CELL_FIRE && (dr == 0 || dc == 0)) fires++;
                end
            end
        end
        ctr = win[1][1];
        case (ctr)
            CELL_FIRE:   nxt = CELL_GROUND;
            CELL_TREE:   nxt = (fires > 0) ? CELL_FIRE : CELL_TREE;
            CELL_GROUND: nxt = (trees > 1) ? CELL_TREE : CELL_GROUND;
            default:     nxt = CELL_OTHER;
        endcase
        last = (emit_cnt + 1 == total);
        emit_cnt++;
        if (emit_cnt >= total) begin
            col_pos  = 0;
            row_pos  = 0;
            emit_cnt = 0;
        end
        return 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        t_cell nxt;
        logic  last;
        t_due  due;
        t_cell got;
        if (!i_rst_n) begin
            due_cells.delete();
            side_reg = CFG_W'(GRID_SIZE_RESET);
            for (int i = 0; i < MAX_SIDE_DEF; i++) begin
                upper_line[i]  = CELL_GROUND;
                middle_line[i] = CELL_GROUND;
            end
            restart_frame();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                side_reg = i_cfg_data;
                restart_frame();
            end
            if (i_s_valid && i_s_ready) begin
                if (step_automaton(i_s_user, t_cell'(i_s_data[1:0]), nxt, last)) begin
                    due.code = nxt;
                    due.last = last;
                    due_cells.push_back(due);
                end
            end
            if (i_m_valid && i_m_ready) begin
                got = t_cell'(i_m_data[1:0]);
                if (due_cells.size() == 0) begin
                    note_failure($sformatf("unexpected result beat: cell %0d last %0b",
                                           got, i_m_last));
                end else begin
                    due = due_cells.pop_front();
                    o_checked++;
                    if (got != due.code || i_m_last != due.last)
                        note_failure($sformatf(
                            "result %0d mismatch: expected cell %0d last %0b, got cell %0d last %0b",
                            o_checked, due.code, due.last, got, i_m_last));
                end
            end
        end
        o_pending = due_cells.size();
    end

endmodule

// ===== verif/forest_fire_automaton_step_top_test.sv =====
`timescale 1ns / 1ps
// Top of the forest-fire automaton step testbench: clock, reset, stimulus and verdict.
// Depends on ffa_pkg, the block under test and ffa_result_checker.
module forest_fire_automaton_step_top_test;
    import ffa_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;    // [1:0] cell_code, [7:2] zero
    logic             s_axis_tuser;    // [0] mode
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;    // [1:0] next_cell, [7:2] zero
    logic             m_axis_tlast;    // last_of_frame

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping and the idling knobs shared with the receiver process.
    int items_sent = 0;
    int cfg_writes = 0;
    int cur_side   = GRID_SIZE_RESET;
    int src_idle   = 31;
    int dst_idle   = 78;
    int hold_seq   = 0;

    forest_fire_automaton_step_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ffa_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_last     (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver. It stalls at random according to dst_idle, and whenever the
    // stimulus bumps hold_seq it holds tready low for a long stretch so that the
    // block backs up and has to stall its input side.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    // Cell codes are biased toward trees, with fire less common, so that the rules
    // that need neighbors (catching fire, growing) trigger often.
    function automatic t_cell rand_cell();
        int r;
        r = $urandom_range(99);
        if (r < 35) return CELL_GROUND;
        if (r < 75) return CELL_TREE;
        if (r < 90) return CELL_FIRE;
        return CELL_OTHER;
    endfunction

    // Offers one beat and returns at the edge where it is taken. tvalid is left
    // high so that back-to-back beats carry no bubble unless the sender idles.
    task automatic send_item(input logic flush, input t_cell code);
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, code};
        s_axis_tuser  <= flush;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Waits until every predicted result has come out, then lets the pipeline run
    // dry, since beats that produce no result may still be in flight when the last
    // expected result appears.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
    endtask

    // Grid size writes happen only with the block idle; each one restarts the frame.
    task automatic write_cfg(input int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        if (value < 1) cur_side = 1;
        else if (value > MAX_SIDE_DEF) cur_side = MAX_SIDE_DEF;
        else cur_side = value;
    endtask

    // One frame at the current side: n*n cells followed by n+1 flush beats. A
    // well-formed frame carries a little noise (a stray flush inside the grid, a
    // stray cell among the drain beats); a broken one stops early with random modes.
    task automatic run_frame(input bit broken, input int cut);
        int len;
        int grid;
        logic flush;
        grid = cur_side * cur_side;
        len  = grid + cur_side + 1;
        if (broken) len = (cut > 0) ? cut : $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) begin
            if (broken) flush = ($urandom_range(3) == 0);
            else if (i < grid) flush = ($urandom_range(99) < 4);
            else flush = ($urandom_range(99) >= 8);
            send_item(flush, rand_cell());
        end
    endtask

    // Mostly small sides, since frame length grows with the square of the side.
    function automatic int pick_side();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(1, 5);
        if (r < 80) return $urandom_range(6, 12);
        if (r < 90) return 2;
        return $urandom_range(13, 20);
    endfunction

    task automatic run_phase(input int budget);
        int  start;
        bit  broken;
        bit  need_cfg;
        start    = items_sent;
        need_cfg = 1'b1;
        while (items_sent - start < budget) begin
            broken = ($urandom_range(99) < 20);
            // A frame may follow the previous one without a write, which checks
            // the wrap back to a new frame and the line stores carried across.
            if (need_cfg || $urandom_range(1)) write_cfg(pick_side());
            run_frame(broken, 0);
            need_cfg = broken;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. At the reset side of 64 a handful of beats never reach
        // the result lag, so they must produce nothing; the block also has to
        // finish clearing its line stores before it takes them.
        send_item(1'b0, CELL_GROUND);
        send_item(1'b0, CELL_TREE);
        send_item(1'b0, CELL_FIRE);
        send_item(1'b0, CELL_OTHER);
        send_item(1'b1, CELL_TREE);

        // A 3x3 grid that hits every rule:
        //   G T T     corner ground with two tree neighbors grows a tree,
        //   T G F     the tree next to fire catches, fire burns out,
        //   T O f     code 3 passes, a tree away from fire stays a tree,
        // and the bottom-right cell arrives as a flush beat inside the grid, so it
        // counts as ground. Among the drain beats one cell beat lies beyond the
        // grid and must be treated as padding.
        write_cfg(3);
        send_item(1'b0, CELL_GROUND);
        send_item(1'b0, CELL_TREE);
        send_item(1'b0, CELL_TREE);
        send_item(1'b0, CELL_TREE);
        send_item(1'b0, CELL_GROUND);
        send_item(1'b0, CELL_FIRE);
        send_item(1'b0, CELL_TREE);
        send_item(1'b0, CELL_OTHER);
        send_item(1'b1, CELL_FIRE);
        send_item(1'b1, CELL_GROUND);
        send_item(1'b0, CELL_TREE);
        send_item(1'b1, CELL_GROUND);
        send_item(1'b1, CELL_GROUND);

        // Single-cell grid: every neighbor is padding.
        write_cfg(1);
        send_item(1'b0, CELL_FIRE);
        send_item(1'b1, CELL_GROUND);
        send_item(1'b1, CELL_GROUND);

        // Random part, phase one: sender idles lightly, receiver heavily. A side
        // of zero must behave as one.
        write_cfg(0);
        run_frame(1'b0, 0);
        run_phase(150);

        // Phase two: roles swapped. Sides above the maximum clamp to it; partial
        // frames at the largest side cover the long line stores.
        src_idle = 78;
        dst_idle = 31;
        write_cfg(65);
        run_frame(1'b1, 120);
        write_cfg(64);
        run_frame(1'b1, 80);
        run_phase(150);

        // Phase three: no idling. One long receiver hold-off fills the block,
        // then a partial frame at the clamped largest side.
        src_idle = 0;
        dst_idle = 0;
        write_cfg(10);
        hold_seq++;
        run_frame(1'b0, 0);
        run_phase(100);
        write_cfg(127);
        run_frame(1'b1, 120);

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d cell-stream beats over %0d grid size writes, %0d results checked.",
                 items_sent, cfg_writes, checked);
        $display("Sides from 1 to the clamped maximum, three idling mixes and one long output stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_line_store.sv
hw/rtl/ffa_rule.sv
hw/rtl/forest_fire_automaton_step_top.sv
verif/ffa_result_checker.sv
verif/forest_fire_automaton_step_top_test.sv
